// ===== hdl/top_peaks_per_mass_window_defines.svh =====
// ---------------------------------------------------------------------------
// Top peaks per mass window: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef TOP_PEAKS_PER_MASS_WINDOW_DEFINES_SVH
`define TOP_PEAKS_PER_MASS_WINDOW_DEFINES_SVH

// same-cycle implication
`define TPW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TPW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/tpw_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Top peaks per mass window: package
// Sizes, window constants, cell types, controller states and the divide by
// one hundred used to find window numbers.
// ---------------------------------------------------------------------------
package tpw_pkg;

	localparam int TOP_K = 10;

	localparam logic [17:0] RECIP_100 = 18'd167773;
	localparam int RECIP_SH = 24;

	typedef struct packed {
		logic        valid;
		logic [31:0] mz;
		logic [31:0] inten;
	} cell_t;

	typedef struct packed {
		logic        insert;
		logic        shift;
		logic [31:0] mz;
		logic [31:0] inten;
	} cell_cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_WIN,
		S_DRAIN,
		S_INS
	} state_t;

	// floor(x / 100), exact for every 16-bit x
	function automatic logic [9:0] div100(input logic [15:0] x);
		logic [33:0] p;
		p = {18'd0, x} * {16'd0, RECIP_100};
		return p[RECIP_SH+9:RECIP_SH];
	endfunction

endpackage

// ===== hdl/tpw_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Top peaks per mass window: sorting cell
// Holds one kept peak. On insert, takes the new peak or its upper neighbor's
// peak; on shift, takes its lower neighbor's peak toward the output.
// ---------------------------------------------------------------------------
module tpw_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  tpw_pkg::cell_cmd_t cmd,
	input  logic              take_prev,
	input  tpw_pkg::cell_t    prev,
	input  tpw_pkg::cell_t    next,
	output logic              take,
	output tpw_pkg::cell_t    cur
);

	logic        valid_q;
	logic [31:0] mz_q;
	logic [31:0] inten_q;

	assign take = cmd.insert && (!valid_q || (inten_q < cmd.inten));

	assign cur.valid = valid_q;
	assign cur.mz    = mz_q;
	assign cur.inten = inten_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.shift) begin
			valid_q <= next.valid;
		end else if (take) begin
			valid_q <= take_prev ? prev.valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			mz_q    <= next.mz;
			inten_q <= next.inten;
		end else if (take) begin
			mz_q    <= take_prev ? prev.mz : cmd.mz;
			inten_q <= take_prev ? prev.inten : cmd.inten;
		end
	end

endmodule

// ===== hdl/top_peaks_per_mass_window.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Top peaks per mass window
// Groups ascending m/z peaks into 100 Da windows, keeps the strongest TOP_K
// per window in a chain of sorting cells and drains them best first.
// Each accepted peak passes S_DIV and S_WIN, then S_DRAIN when it lies past
// the open window, then S_INS; a final peak then drains the open window too.
// in_stall holds off new peaks outside S_IDLE. A drain shifts one cell a
// cycle into the output register while the output is free (not stalled).
// Reset: arst_n clears control, cell valid bits and the open spectrum.
// ---------------------------------------------------------------------------
module top_peaks_per_mass_window (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] peak_mz,
	input  logic [31:0] peak_intensity,
	input  logic        last_peak,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [9:0]  window_index,
	output logic [3:0]  rank,
	output logic [31:0] out_mz,
	output logic [31:0] out_intensity,
	output logic        run_end,
	output logic        spectrum_done
);

	`include "top_peaks_per_mass_window_defines.svh"

	tpw_pkg::state_t    state_q, state_d;
	tpw_pkg::cell_cmd_t cmd;
	tpw_pkg::cell_t     cells [tpw_pkg::TOP_K];
	logic               takes [tpw_pkg::TOP_K];
	logic [tpw_pkg::TOP_K-1:0] v;
	logic [tpw_pkg::TOP_K:0]   v_inc;

	logic [31:0] in_mz_q, in_int_q;
	logic        in_last_q;
	logic [15:0] div_in_q;
	logic        beyond_q;
	logic [9:0]  div_q;
	logic [31:0] base_q;
	logic [9:0]  open_q;
	logic [32:0] upper_q;
	logic        started_q;
	logic        fin_q;
	logic [3:0]  rank_q;

	logic        out_valid_q;
	logic [9:0]  out_win_q;
	logic [3:0]  out_rank_q;
	logic [31:0] out_mz_q, out_int_q;
	logic        out_end_q, out_done_q;

	logic        accept, out_free, pop;
	logic [31:0] diff;
	logic [15:0] base_hi;
	logic [16:0] up_hi;

	genvar gi;
	generate
		for (gi = 0; gi < tpw_pkg::TOP_K; gi++) begin : g_cell
			tpw_pkg::cell_t prev_c, next_c;
			logic           take_prev;
			if (gi == 0) begin : g_first
				assign prev_c    = '0;
				assign take_prev = 1'b0;
			end else begin : g_mid
				assign prev_c    = cells[gi-1];
				assign take_prev = takes[gi-1];
			end
			if (gi == tpw_pkg::TOP_K - 1) begin : g_last
				assign next_c = '0;
			end else begin : g_inner
				assign next_c = cells[gi+1];
			end
			tpw_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.take_prev (take_prev),
				.prev      (prev_c),
				.next      (next_c),
				.take      (takes[gi]),
				.cur       (cells[gi])
			);
			assign v[gi] = cells[gi].valid;
		end
	endgenerate

	assign v_inc = {1'b0, v} + 1'b1;

	assign in_stall = (state_q != tpw_pkg::S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign diff     = peak_mz - base_q - 32'd1;
	assign base_hi  = 16'({6'd0, div_q} * 16'd100);
	assign up_hi    = 17'(({7'd0, open_q} + 17'd1) * 17'd100);

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.mz    = in_mz_q;
		cmd.inten = in_int_q;
		pop       = 1'b0;
		case (state_q)
			tpw_pkg::S_IDLE: begin
				if (accept) state_d = tpw_pkg::S_DIV;
			end
			tpw_pkg::S_DIV: begin
				state_d = tpw_pkg::S_WIN;
			end
			tpw_pkg::S_WIN: begin
				state_d = beyond_q ? tpw_pkg::S_DRAIN : tpw_pkg::S_INS;
			end
			tpw_pkg::S_DRAIN: begin
				if (v[0]) begin
					pop       = out_free;
					cmd.shift = out_free;
				end else begin
					state_d = fin_q ? tpw_pkg::S_IDLE : tpw_pkg::S_INS;
				end
			end
			tpw_pkg::S_INS: begin
				cmd.insert = 1'b1;
				state_d    = in_last_q ? tpw_pkg::S_DRAIN : tpw_pkg::S_IDLE;
			end
			default: begin
				state_d = tpw_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpw_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			base_q    <= '0;
			open_q    <= '0;
			upper_q   <= '0;
			fin_q     <= 1'b0;
			rank_q    <= '0;
		end else begin
			case (state_q)
				tpw_pkg::S_WIN: begin
					rank_q <= '0;
					fin_q  <= 1'b0;
					if (!beyond_q && !started_q) begin
						base_q    <= {base_hi, 16'd0};
						open_q    <= '0;
						started_q <= 1'b1;
					end
				end
				tpw_pkg::S_DRAIN: begin
					if (pop) begin
						rank_q <= rank_q + 4'd1;
					end else if (!v[0]) begin
						if (fin_q) begin
							started_q <= 1'b0;
							base_q    <= '0;
							open_q    <= '0;
							fin_q     <= 1'b0;
						end else begin
							open_q <= div_q;
						end
					end
				end
				tpw_pkg::S_INS: begin
					upper_q <= {1'b0, base_q} + {up_hi, 16'd0};
					rank_q  <= '0;
					fin_q   <= in_last_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_mz_q   <= peak_mz;
			in_int_q  <= peak_intensity;
			in_last_q <= last_peak;
			beyond_q  <= started_q && ({1'b0, peak_mz} > upper_q);
			div_in_q  <= started_q ? diff[31:16] : peak_mz[31:16];
		end
		if (state_q == tpw_pkg::S_DIV) begin
			div_q <= tpw_pkg::div100(div_in_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_win_q  <= open_q;
			out_rank_q <= rank_q;
			out_mz_q   <= cells[0].mz;
			out_int_q  <= cells[0].inten;
			out_end_q  <= !(|(v >> 1)) && (fin_q || !in_last_q);
			out_done_q <= in_last_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign window_index  = out_win_q;
	assign rank          = out_rank_q;
	assign out_mz        = out_mz_q;
	assign out_intensity = out_int_q;
	assign run_end       = out_end_q;
	assign spectrum_done = out_done_q;

	`TPW_ASSERT_NOW(a_kept_contig, 1'b1, $onehot(v_inc), "kept peaks not packed from the head")
	`TPW_ASSERT_NOW(a_open_nonempty, (state_q == tpw_pkg::S_IDLE) && started_q, v[0],
		"open window holds no peak")
	`TPW_ASSERT_NXT(a_out_hold, out_valid_q && out_stall,
		out_valid_q && $stable(out_mz_q) && $stable(out_int_q) && $stable(out_rank_q)
		&& $stable(out_win_q), "stalled result changed")
	`TPW_ASSERT_NXT(a_final_clears, (state_q == tpw_pkg::S_DRAIN) && fin_q && !v[0],
		!started_q && (state_q == tpw_pkg::S_IDLE), "spectrum not closed after final drain")
	`TPW_ASSERT_NOW(a_pop_only_drain, pop, (state_q == tpw_pkg::S_DRAIN) && v[0],
		"result loaded outside a drain")

endmodule

// ===== tb/sv/tb_top_peaks_per_mass_window.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Top peaks per mass window: testbench
// Drives spectra of peaks through the valid/stall input channel and checks
// every window drain against a local model of the per-window top-k sort.
// A short table covers edges, ties, a full window, window jumps and the
// largest drain, then random spectra follow with bursts of idling and
// stalling on both sides, ending with a stretch at full rate.
// ---------------------------------------------------------------------------
module tb_top_peaks_per_mass_window;

	localparam int unsigned WIN_Q = 32'd6553600;
	localparam int DIR_N = 20;
	localparam int RAND_ITEMS = 90;
	localparam int QUIET_ITEMS = 25;
	localparam int SETTLE_CYCLES = 64;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [9:0]  win;
		logic [3:0]  rank;
		logic [31:0] mz;
		logic [31:0] inten;
		logic        run_end;
		logic        done;
	} kept_peak_t;

	typedef struct packed {
		logic [31:0] mz;
		logic [31:0] inten;
		logic        is_last;
		logic        typed;
		kept_peak_t  want;
	} stim_row_t;

	localparam stim_row_t DIRECTED [DIR_N] = '{
		'{32'h00000000, 32'h00000000, 1'b1, 1'b1,
			'{10'd0, 4'd0, 32'h00000000, 32'h00000000, 1'b1, 1'b1}},
		'{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1,
			'{10'd0, 4'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1}},
		'{32'h00C88000, 32'd10, 1'b0, 1'b0, '0},
		'{32'h00960000, 32'd20, 1'b0, 1'b0, '0},
		'{32'h012C0000, 32'd10, 1'b0, 1'b0, '0},
		'{32'h012C0001, 32'd1, 1'b0, 1'b0, '0},
		'{32'hFFFFFFFF, 32'd0, 1'b1, 1'b0, '0},
		'{32'h03E80000, 32'd100, 1'b0, 1'b0, '0},
		'{32'h03E90000, 32'd50, 1'b0, 1'b0, '0},
		'{32'h03EA0000, 32'd50, 1'b0, 1'b0, '0},
		'{32'h03EB0000, 32'd200, 1'b0, 1'b0, '0},
		'{32'h03EC0000, 32'd50, 1'b0, 1'b0, '0},
		'{32'h03ED0000, 32'd50, 1'b0, 1'b0, '0},
		'{32'h03EE0000, 32'd50, 1'b0, 1'b0, '0},
		'{32'h03EF0000, 32'd50, 1'b0, 1'b0, '0},
		'{32'h03F00000, 32'd50, 1'b0, 1'b0, '0},
		'{32'h03F10000, 32'd50, 1'b0, 1'b0, '0},
		'{32'h03F20000, 32'd50, 1'b0, 1'b0, '0},
		'{32'h03F30000, 32'd60, 1'b0, 1'b0, '0},
		'{32'h04B00000, 32'd7, 1'b1, 1'b0, '0}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] peak_mz;
	logic [31:0] peak_intensity;
	logic        last_peak;
	logic        out_valid;
	logic        out_stall;
	logic [9:0]  window_index;
	logic [3:0]  rank;
	logic [31:0] out_mz;
	logic [31:0] out_intensity;
	logic        run_end;
	logic        spectrum_done;

	top_peaks_per_mass_window dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.peak_mz(peak_mz),
		.peak_intensity(peak_intensity),
		.last_peak(last_peak),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.window_index(window_index),
		.rank(rank),
		.out_mz(out_mz),
		.out_intensity(out_intensity),
		.run_end(run_end),
		.spectrum_done(spectrum_done)
	);

	logic [31:0] top_mz [tpw_pkg::TOP_K];
	logic [31:0] top_inten [tpw_pkg::TOP_K];
	int unsigned top_count;
	int unsigned open_win;
	logic [31:0] base_mz;
	bit          spectrum_open;
	kept_peak_t  kept_q [$];

	int    errors;
	int    peaks_sent;
	int    spectra_sent;
	int    drains_checked;
	int    widest_step;
	int    cycles;
	bit    quiet;

	initial begin
		clk = 1'b0;
	end

	always #6 clk = ~clk;

	function automatic int drain_window(input logic done);
		int unsigned i;
		kept_peak_t r;
		for (i = 0; i < top_count; i++) begin
			r.win = open_win[9:0];
			r.rank = 4'(i);
			r.mz = top_mz[i];
			r.inten = top_inten[i];
			r.run_end = 1'b0;
			r.done = done;
			kept_q.insert(kept_q.size(), r);
		end
		drain_window = int'(top_count);
		top_count = 0;
	endfunction

	function automatic int predict_peak(input logic [31:0] mz, input logic [31:0] inten,
			input logic is_last);
		int n;
		int unsigned pos;
		int unsigned j;
		longint unsigned upper;
		longint unsigned span;
		kept_peak_t tail;
		n = 0;
		if (!spectrum_open) begin
			base_mz = (mz / WIN_Q) * WIN_Q;
			open_win = 0;
			top_count = 0;
			spectrum_open = 1'b1;
		end else begin
			upper = longint'(base_mz) + (longint'(open_win) + 1) * longint'(WIN_Q);
			if (longint'(mz) > upper) begin
				span = longint'(mz) - longint'(base_mz);
				n += drain_window(is_last);
				open_win = int'((span + WIN_Q - 1) / WIN_Q - 1);
			end
		end
		pos = 0;
		while (pos < top_count && top_inten[pos] >= inten)
			pos++;
		if (pos < tpw_pkg::TOP_K) begin
			j = (top_count < tpw_pkg::TOP_K) ? top_count : tpw_pkg::TOP_K - 1;
			while (j > pos) begin
				top_mz[j] = top_mz[j - 1];
				top_inten[j] = top_inten[j - 1];
				j--;
			end
			top_mz[pos] = mz;
			top_inten[pos] = inten;
			if (top_count < tpw_pkg::TOP_K)
				top_count++;
		end
		if (is_last) begin
			n += drain_window(1'b1);
			spectrum_open = 1'b0;
			open_win = 0;
			base_mz = '0;
		end
		if (n > 0) begin
			tail = kept_q[kept_q.size() - 1];
			tail.run_end = 1'b1;
			kept_q[kept_q.size() - 1] = tail;
		end
		if (n > widest_step)
			widest_step = n;
		predict_peak = n;
	endfunction

	function automatic int field_bad(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	task automatic send_peak(input logic [31:0] mz, input logic [31:0] inten,
			input logic is_last, output int n);
		in_valid <= 1'b1;
		peak_mz <= mz;
		peak_intensity <= inten;
		last_peak <= is_last;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		n = predict_peak(mz, inten, is_last);
		peaks_sent++;
		if (is_last)
			spectra_sent++;
	endtask

	task automatic maybe_idle();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// random stall bursts on the result side
	initial begin
		bit stalling;
		int hold;
		stalling = 1'b0;
		hold = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (quiet) begin
				stalling = 1'b0;
				hold = 0;
			end else if (hold > 0) begin
				hold--;
			end else if (stalling) begin
				stalling = 1'b0;
				hold = $urandom_range(0, 19);
			end else if ($urandom_range(0, 1) == 0) begin
				stalling = 1'b1;
				hold = $urandom_range(0, 14);
			end else begin
				hold = $urandom_range(0, 19);
			end
			out_stall <= stalling;
		end
	end

	always @(posedge clk) begin
		kept_peak_t head;
		int bad;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (kept_q.size() == 0) begin
				$display("%0t: result with none expected: window %0d rank %0d mz %0h",
					$time, window_index, rank, out_mz);
				errors++;
			end else begin
				head = kept_q.pop_front();
				bad = 0;
				bad += field_bad("window_index", 32'(head.win), 32'(window_index));
				bad += field_bad("rank", 32'(head.rank), 32'(rank));
				bad += field_bad("out_mz", head.mz, out_mz);
				bad += field_bad("out_intensity", head.inten, out_intensity);
				bad += field_bad("run_end", 32'(head.run_end), 32'(run_end));
				bad += field_bad("spectrum_done", 32'(head.done), 32'(spectrum_done));
				errors += bad;
				drains_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, kept_q.size());
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int n;
		int row;
		int spec_len;
		int k;
		longint unsigned next_mz;
		logic [31:0] mz;
		logic [31:0] inten;
		kept_peak_t got;

		arst_n = 1'b0;
		in_valid = 1'b0;
		peak_mz = '0;
		peak_intensity = '0;
		last_peak = 1'b0;
		quiet = 1'b0;
		errors = 0;
		peaks_sent = 0;
		spectra_sent = 0;
		drains_checked = 0;
		widest_step = 0;
		cycles = 0;
		top_count = 0;
		open_win = 0;
		base_mz = '0;
		spectrum_open = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < DIR_N; row++) begin
			send_peak(DIRECTED[row].mz, DIRECTED[row].inten, DIRECTED[row].is_last, n);
			if (DIRECTED[row].typed) begin
				got = kept_q[kept_q.size() - 1];
				if (n != 1 || got !== DIRECTED[row].want) begin
					$display("%0t: row %0d expected %0h got %0h (%0d results)",
						$time, row, DIRECTED[row].want, got, n);
					errors++;
				end
			end
			maybe_idle();
		end

		while (peaks_sent < DIR_N + RAND_ITEMS) begin
			spec_len = $urandom_range(1, 30);
			if (spec_len > DIR_N + RAND_ITEMS - peaks_sent)
				spec_len = DIR_N + RAND_ITEMS - peaks_sent;
			case ($urandom_range(0, 3))
				0: mz = $urandom;
				1: mz = $urandom_range(0, 32'h00FFFFFF);
				2: mz = 32'hFFF00000 + $urandom_range(0, 32'h000FFFFF);
				default: mz = $urandom_range(0, 655) * WIN_Q;
			endcase
			for (k = 0; k < spec_len; k++) begin
				if (peaks_sent >= DIR_N + RAND_ITEMS - QUIET_ITEMS)
					quiet = 1'b1;
				inten = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 7)) : $urandom;
				send_peak(mz, inten, k == spec_len - 1, n);
				maybe_idle();
				next_mz = longint'(mz);
				case ($urandom_range(0, 19))
					0, 1: ;
					2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13:
						next_mz += $urandom_range(1, 32'h00080000);
					14, 15, 16: next_mz = (next_mz / WIN_Q + 1) * WIN_Q;
					17: next_mz += $urandom_range(WIN_Q, 8 * WIN_Q);
					18: next_mz = (next_mz > 32'h00200000) ?
						next_mz - $urandom_range(1, 32'h00200000) : 0;
					default: next_mz += 1;
				endcase
				mz = (next_mz > 64'hFFFFFFFF) ? 32'hFFFFFFFF : next_mz[31:0];
			end
		end
		in_valid <= 1'b0;

		while (kept_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d peaks in %0d spectra; checked %0d kept-peak results.",
			peaks_sent, spectra_sent, drains_checked);
		$display("Largest drain from one peak: %0d results; %0d field errors.",
			widest_step, errors);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== top_peaks_per_mass_window.f =====
+incdir+hdl
hdl/tpw_pkg.sv
hdl/tpw_cell.sv
hdl/top_peaks_per_mass_window.sv
tb/sv/tb_top_peaks_per_mass_window.sv
